// ===== rtl/divenum_pkg.sv =====
// shared types and constants for the divisor enumerator
package divenum_pkg;

  // width of the divisor result port
  localparam int unsigned DIV_W = 13;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_TRIAL   = 5'b00010,
    ST_WAIT    = 5'b00100,
    ST_POP_RD  = 5'b01000,
    ST_POP_OUT = 5'b10000
  } divenum_state_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } divenum_div_sts_t;

endpackage

// ===== rtl/divenum_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module divenum_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/divenum_div.sv =====
// restoring divider, one quotient bit per cycle
module divenum_div
  import divenum_pkg::*;
#(
  parameter int unsigned N_BITS = 13,
  parameter int unsigned D_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [N_BITS-1:0]   dividend_i,
  input  logic [D_BITS-1:0]   divisor_i,
  output divenum_div_sts_t    status_o,
  output logic [N_BITS-1:0]   quotient_o
);

  localparam int unsigned CW = $clog2(N_BITS + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [D_BITS-1:0] dvs_q, dvs_d;
  logic [D_BITS-1:0] rem_q, rem_d;
  logic [N_BITS-1:0] quo_q, quo_d;
  logic [D_BITS:0]   trial;
  logic [D_BITS:0]   diff;
  logic              fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[N_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d  = CW'(N_BITS);
      busy_d = 1'b1;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
      quo_d = {quo_q[N_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);
  assign quotient_o        = quo_q;

endmodule

// ===== rtl/divisor_enumerator.sv =====
// top level of the divisor enumerator
//
// usage: drive n_value_i and raise start; the transfer happens on a rising
// edge with start high and busy low. the block then lists every divisor of
// n in ascending order, one per cycle of res_strobe_o, with last_o set on
// the final one. n = 0 gives a single result with divisor 0, last_o and
// empty_res_o set.
// operation: trial divisors i = 1, 2, ... run while i*i <= n, each through
// a bit-serial divider. small divisors come out as the trials find them;
// their partners n/i go on a stack held in a synchronous ram and are
// popped after the trials, each pop a ram read, then a result.
// busy is high from the transfer until the final result is registered
// (for n = 1 it stays high through a last pass of ST_TRIAL; it never rises
// for n = 0).
// results are registered and shown for exactly one cycle; the receiver
// cannot stall, so nothing is held back. reset returns the sequencer to
// idle with no result pending; the stack ram needs no clearing since only
// entries pushed for the current number are popped.
module divisor_enumerator
  import divenum_pkg::*;
#(
  parameter int unsigned N_BITS      = 13,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [N_BITS-1:0] n_value_i,
  output logic              res_strobe_o,
  output logic [DIV_W-1:0]  divisor_o,
  output logic              last_o,
  output logic              empty_res_o
);

  // trial divisor width: must hold the first i with i*i > n
  localparam int unsigned I_BITS  = (N_BITS + 1) / 2 + 1;
  localparam int unsigned SQ_BITS = 2 * I_BITS;
  localparam int unsigned AW      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);

  divenum_state_e state_q, state_d;

  logic [N_BITS-1:0]  n_q, n_d;
  logic [I_BITS-1:0]  i_q, i_d;     // trial divisor
  logic [SQ_BITS-1:0] sq_q, sq_d;   // i*i kept incrementally
  logic [CNT_W-1:0]   cnt_q, cnt_d; // stack fill

  // result register
  logic               strobe_q, strobe_d;
  logic [DIV_W-1:0]   div_q, div_d;
  logic               last_q, last_d;
  logic               empty_q, empty_d;

  // divider
  logic               div_start;
  divenum_div_sts_t   div_sts;
  logic [N_BITS-1:0]  quo;
  logic [N_BITS-1:0]  i_ext;

  // stack ram
  logic               push;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [N_BITS-1:0]  rdata;
  logic               stack_full;
  logic [CNT_W-1:0]   cnt_dec;

  assign i_ext      = N_BITS'(i_q);
  assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
  assign cnt_dec    = cnt_q - 1'b1;
  assign waddr      = cnt_q[AW-1:0];
  assign raddr      = cnt_dec[AW-1:0];

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    sq_d      = sq_q;
    cnt_d     = cnt_q;
    strobe_d  = 1'b0;
    div_d     = div_q;
    last_d    = last_q;
    empty_d   = empty_q;
    div_start = 1'b0;
    push      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d   = n_value_i;
          i_d   = I_BITS'(1);
          sq_d  = SQ_BITS'(1);
          cnt_d = '0;
          if (n_value_i == '0) begin
            // zero has no divisors: one empty result
            strobe_d = 1'b1;
            div_d    = '0;
            last_d   = 1'b1;
            empty_d  = 1'b1;
          end else begin
            state_d = ST_TRIAL;
          end
        end
      end

      ST_TRIAL: begin
        if (sq_q > SQ_BITS'(n_q)) begin
          // trials over, drain the partners
          state_d = (cnt_q == '0) ? ST_IDLE : ST_POP_RD;
        end else begin
          div_start = 1'b1;
          state_d   = ST_WAIT;
        end
      end

      ST_WAIT: begin
        if (div_sts.done) begin
          if (div_sts.rem_zero) begin
            strobe_d = 1'b1;
            div_d    = DIV_W'(i_q);
            empty_d  = 1'b0;
            // square root with nothing stacked ends the list here
            last_d   = (quo == i_ext) && (cnt_q == '0);
            if ((quo != i_ext) && !stack_full) begin
              push  = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
          end
          i_d     = i_q + 1'b1;
          sq_d    = sq_q + SQ_BITS'({i_q, 1'b1});
          state_d = ST_TRIAL;
        end
      end

      ST_POP_RD: begin
        cnt_d   = cnt_dec;
        state_d = ST_POP_OUT;
      end

      ST_POP_OUT: begin
        strobe_d = 1'b1;
        div_d    = DIV_W'(rdata);
        empty_d  = 1'b0;
        last_d   = (cnt_q == '0);
        state_d  = (cnt_q == '0) ? ST_IDLE : ST_POP_RD;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      i_q      <= I_BITS'(1);
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      i_q      <= i_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    sq_q    <= sq_d;
    div_q   <= div_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

  divenum_div #(
    .N_BITS (N_BITS),
    .D_BITS (I_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (i_q),
    .status_o   (div_sts),
    .quotient_o (quo)
  );

  divenum_ram #(
    .WIDTH (N_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (waddr),
    .wdata_i (quo),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign divisor_o    = div_q;
  assign last_o       = last_q;
  assign empty_res_o  = empty_q;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the divisor enumerator
module tb;
  import divenum_pkg::*;

  localparam int unsigned N_BITS       = 13;
  localparam int unsigned STACK_DEPTH  = 32;
  // a 13-bit number has at most 64 divisors
  localparam int unsigned MAX_DIVISORS = 64;
  localparam int unsigned RANDOM_ITEMS = 500;
  // idle percentages of the sender in the first two thirds; none in the last
  localparam int unsigned GAP_PCT_LOW  = 16;
  localparam int unsigned GAP_PCT_HIGH = 76;
  // every this many items the sender waits until all results are back
  localparam int unsigned DRAIN_EVERY  = 100;
  // cycles to watch for stray results after the last expected one
  localparam int unsigned TAIL_CYCLES  = 40;

  // one expected result transfer
  typedef struct packed {
    logic [DIV_W-1:0] divisor;
    logic             is_last;
    logic             is_empty;
  } div_result_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start     = 1'b0;
  logic [N_BITS-1:0] n_value_i = '0;
  logic              busy;
  logic              res_strobe_o;
  logic [DIV_W-1:0]  divisor_o;
  logic              last_o;
  logic              empty_res_o;

  // numbers still to be sent, and divisors still to come back
  logic [N_BITS-1:0] pending_n[$];
  div_result_t       expected_divisors[$];

  int unsigned total_items  = 0;
  int unsigned taken_cnt    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;

  divisor_enumerator #(
    .N_BITS      (N_BITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .n_value_i    (n_value_i),
    .res_strobe_o (res_strobe_o),
    .divisor_o    (divisor_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o)
  );

  always #5 clk_i = ~clk_i;

  // append a number to the send queue
  function automatic void queue_number(input logic [N_BITS-1:0] n);
    pending_n.insert(pending_n.size(), n);
  endfunction

  // append one result to the expected queue
  function automatic void expect_result(input div_result_t r);
    expected_divisors.insert(expected_divisors.size(), r);
  endfunction

  // trial division up to sqrt(n); small divisors go out at once, their
  // partners are stacked and popped afterwards so the list stays ascending
  function automatic void predict_divisors(input logic [N_BITS-1:0] n);
    logic [DIV_W-1:0] partners[STACK_DEPTH];
    logic [DIV_W-1:0] found[MAX_DIVISORS];
    int unsigned      stacked;
    int unsigned      nfound;
    int unsigned      i;
    int unsigned      q;
    int unsigned      k;
    div_result_t      r;
    stacked = 0;
    nfound  = 0;
    if (n == 0) begin
      // no divisor at all: a single result flagged empty
      r = '{divisor: '0, is_last: 1'b1, is_empty: 1'b1};
      expect_result(r);
    end else begin
      for (i = 1; i * i <= n; i++) begin
        if (n % i == 0) begin
          q = n / i;
          if (nfound < MAX_DIVISORS) begin
            found[nfound] = i[DIV_W-1:0];
            nfound++;
          end
          // a square root has no separate partner; a full stack drops it
          if (q != i && stacked < STACK_DEPTH) begin
            partners[stacked] = q[DIV_W-1:0];
            stacked++;
          end
        end
      end
      while (stacked > 0) begin
        stacked--;
        if (nfound < MAX_DIVISORS) begin
          found[nfound] = partners[stacked];
          nfound++;
        end
      end
      for (k = 0; k < nfound; k++) begin
        r.divisor  = found[k];
        r.is_last  = (k == nfound - 1);
        r.is_empty = 1'b0;
        expect_result(r);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input div_result_t want);
    if (mismatch_cnt < 10)
      $display("mismatch %0s: expected div=%0d last=%0b empty=%0b, got div=%0d last=%0b empty=%0b",
               what, want.divisor, want.is_last, want.is_empty,
               divisor_o, last_o, empty_res_o);
    mismatch_cnt++;
  endtask

  // driver: start stays high until the transfer happens, then the next
  // number is offered, possibly after a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap_pct;
    bit          offer;
    if (!rst_ni) begin
      start     <= 1'b0;
      n_value_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_divisors(n_value_i);
        accepted_cnt++;
      end
      // a raised start that the block has not taken yet is left alone
      if (!start || !busy) begin
        if (taken_cnt < total_items / 3)
          gap_pct = GAP_PCT_LOW;
        else if (taken_cnt < 2 * total_items / 3)
          gap_pct = GAP_PCT_HIGH;
        else
          gap_pct = 0;
        offer = pending_n.size() != 0 && $urandom_range(99) >= gap_pct;
        // now and then hold off until the block has delivered everything
        if (taken_cnt != 0 && taken_cnt % DRAIN_EVERY == 0 &&
            expected_divisors.size() != 0)
          offer = 1'b0;
        if (offer) begin
          start     <= 1'b1;
          n_value_i <= pending_n.pop_front();
          taken_cnt++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is one result transfer, checked against the
  // oldest expectation
  always @(posedge clk_i) begin
    div_result_t want;
    if (rst_ni && res_strobe_o === 1'b1) begin
      if (expected_divisors.size() == 0) begin
        want = '0;
        report_mismatch("unexpected result", want);
      end else begin
        want = expected_divisors.pop_front();
        if (divisor_o !== want.divisor || last_o !== want.is_last ||
            empty_res_o !== want.is_empty)
          report_mismatch("in result", want);
      end
    end
  end

  initial begin
    int unsigned sel;
    logic [N_BITS-1:0] directed[$];
    // zero, ones, all-ones, single top bit, alternating patterns, primes,
    // perfect squares (8100 first has the most trials) and the most divisors
    directed = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4, 13'd12, 13'd36, 13'd49,
                 13'd97, 13'd8191, 13'd8190, 13'd4096, 13'd2048, 13'd1365,
                 13'd2730, 13'd5461, 13'd7560, 13'd5040, 13'd6720, 13'd8100,
                 13'd8064, 13'd7919};
    foreach (directed[k]) queue_number(directed[k]);
    // mostly small numbers to keep the run short, a share over the full range
    repeat (RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 3)
        queue_number('0);
      else if (sel < 60)
        queue_number(N_BITS'($urandom_range(255)));
      else if (sel < 85)
        queue_number(N_BITS'($urandom_range(2047)));
      else
        queue_number(N_BITS'($urandom_range(8191)));
    end
    total_items = pending_n.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != total_items || expected_divisors.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_divisors.size() == 0)
      $display("[divisor_enumerator] OK");
    else
      $display("[divisor_enumerator] ERROR");
    $finish;
  end

  // hang guard, several times the slowest plausible run
  initial begin
    #40_000_000;
    $display("[divisor_enumerator] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/divenum_pkg.sv
rtl/divenum_ram.sv
rtl/divenum_div.sv
rtl/divisor_enumerator.sv
tb/sv/tb.sv
